FILE: rtl/core/gcer_pkg.sv
// Shared constants, command codes and control structs for the edge relaxer.
package gcer_pkg;

  localparam int MAX_NODES = 16384;
  localparam int MAX_EDGES = 65536;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int COLOR_W   = 32;
  localparam int CMD_W     = 3;

  localparam logic [COLOR_W-1:0] COLOR_MIN = {1'b1, {(COLOR_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 3'd0,
    CMD_SNAPSHOT = 3'd1,
    CMD_VISIT    = 3'd2,
    CMD_READ     = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_e;

  // Per-vertex walk state carried between edges
  typedef struct packed {
    logic [COLOR_W-1:0] running;
    logic               violated;
    logic               in_prog;
    logic               over;
    logic               stale;
  } relax_state_t;

  // Everything one executed command produces
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               changed;
    logic               over;
    logic [COLOR_W-1:0] running;
    logic               violated;
    logic               in_prog;
    logic               color_we;
    logic [COLOR_W-1:0] color_wdata;
    logic               snap_we;
  } relax_res_t;

endpackage

FILE: rtl/core/graph_coloring_edge_relaxer.sv
// Top level: command sequencer, color and snapshot memories, result register.
//
// Each command is accepted in S_IDLE, where the reads of the color memory
// (at the vertex and at the neighbor, from two mirrored copies) and of the
// snapshot memory are issued; S_EXEC then updates the walk state, writes
// back and loads the result register from the registered read data.
// A command is accepted while an earlier result still waits to be taken;
// S_EXEC then holds until the result register frees. Memory contents are
// undefined after reset; the walk state, the over flag and the snapshot
// select bit reset to zero. The snapshot select bit is written on the
// configuration channel, which is always ready, and must only change while
// no command is in flight.
module graph_coloring_edge_relaxer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_snap_sel_i,
  // Command channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   cmd_i,
  input  logic [13:0]                  vertex_i,
  input  logic [13:0]                  neighbor_i,
  input  logic [15:0]                  edge_index_i,
  input  logic signed [31:0]           color_value_i,
  input  logic                         last_edge_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           color_o,
  output logic                         changed_o,
  output logic                         over_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                       state_q;
  logic [gcer_pkg::CMD_W-1:0]   cmd_q;
  logic [gcer_pkg::NODE_AW-1:0] vertex_q;
  logic [gcer_pkg::NODE_AW-1:0] neighbor_q;
  logic [gcer_pkg::EDGE_AW-1:0] edge_q;
  logic [gcer_pkg::COLOR_W-1:0] value_q;
  logic                         last_q;

  logic [gcer_pkg::COLOR_W-1:0] running_q;
  logic                         violated_q;
  logic                         in_prog_q;
  logic                         over_q;
  logic                         stale_q;

  logic                         out_valid_q;
  logic                         out_valid_d;
  logic [gcer_pkg::COLOR_W-1:0] color_q;
  logic                         changed_q;
  logic                         over_out_q;

  logic                         accept;
  logic                         exec_go;
  logic                         color_we;
  logic                         snap_we;
  logic [gcer_pkg::COLOR_W-1:0] vtx_rd;
  logic [gcer_pkg::COLOR_W-1:0] nbr_rd;
  logic [gcer_pkg::COLOR_W-1:0] snap_rd;
  gcer_pkg::relax_state_t       st;
  gcer_pkg::relax_res_t         res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign exec_go     = (state_q == S_EXEC) && !(out_valid_q && out_stall_i);
  assign color_we    = exec_go && res.color_we;
  assign snap_we     = exec_go && res.snap_we;

  // Keep a waiting result beat, load a new one when the step completes
  assign out_valid_d = exec_go || (out_valid_q && out_stall_i);

  // Color table, vertex-side copy
  gcer_ram #(
    .Width (gcer_pkg::COLOR_W),
    .Depth (gcer_pkg::MAX_NODES)
  ) u_color_vtx (
    .clk_i   (clk_i),
    .we_i    (color_we),
    .waddr_i (vertex_q),
    .wdata_i (res.color_wdata),
    .re_i    (accept),
    .raddr_i (vertex_i),
    .rdata_o (vtx_rd)
  );

  // Color table, neighbor-side copy (mirrors every write)
  gcer_ram #(
    .Width (gcer_pkg::COLOR_W),
    .Depth (gcer_pkg::MAX_NODES)
  ) u_color_nbr (
    .clk_i   (clk_i),
    .we_i    (color_we),
    .waddr_i (vertex_q),
    .wdata_i (res.color_wdata),
    .re_i    (accept),
    .raddr_i (neighbor_i),
    .rdata_o (nbr_rd)
  );

  // Per-edge snapshot table
  gcer_ram #(
    .Width (gcer_pkg::COLOR_W),
    .Depth (gcer_pkg::MAX_EDGES)
  ) u_snap (
    .clk_i   (clk_i),
    .we_i    (snap_we),
    .waddr_i (edge_q),
    .wdata_i (nbr_rd),
    .re_i    (accept),
    .raddr_i (edge_index_i),
    .rdata_o (snap_rd)
  );

  assign st.running  = running_q;
  assign st.violated = violated_q;
  assign st.in_prog  = in_prog_q;
  assign st.over     = over_q;
  assign st.stale    = stale_q;

  gcer_relax u_relax (
    .cmd_i      (cmd_q),
    .vertex_i   (vertex_q),
    .neighbor_i (neighbor_q),
    .value_i    (value_q),
    .last_i     (last_q),
    .vtx_rd_i   (vtx_rd),
    .nbr_rd_i   (nbr_rd),
    .snap_rd_i  (snap_rd),
    .st_i       (st),
    .res_o      (res)
  );

  // Capture the command beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      vertex_q   <= vertex_i;
      neighbor_q <= neighbor_i;
      edge_q     <= edge_index_i;
      value_q    <= color_value_i;
      last_q     <= last_edge_i;
    end
  end

  // Sequencer, walk state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= '0;
      violated_q  <= 1'b0;
      in_prog_q   <= 1'b0;
      over_q      <= 1'b0;
      stale_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        stale_q <= cfg_snap_sel_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            running_q   <= res.running;
            violated_q  <= res.violated;
            in_prog_q   <= res.in_prog;
            over_q      <= res.over;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded when the step completes
  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      color_q    <= res.color;
      changed_q  <= res.changed;
      over_out_q <= res.over;
    end
  end

  assign out_valid_o = out_valid_q;
  assign color_o     = color_q;
  assign changed_o   = changed_q;
  assign over_o      = over_out_q;

endmodule

FILE: rtl/core/gcer_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gcer_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/gcer_relax.sv
// Read-modify-write step: decodes one command against the memory read data.
module gcer_relax (
  input  logic [gcer_pkg::CMD_W-1:0]   cmd_i,
  input  logic [gcer_pkg::NODE_AW-1:0] vertex_i,
  input  logic [gcer_pkg::NODE_AW-1:0] neighbor_i,
  input  logic [gcer_pkg::COLOR_W-1:0] value_i,
  input  logic                         last_i,
  input  logic [gcer_pkg::COLOR_W-1:0] vtx_rd_i,
  input  logic [gcer_pkg::COLOR_W-1:0] nbr_rd_i,
  input  logic [gcer_pkg::COLOR_W-1:0] snap_rd_i,
  input  gcer_pkg::relax_state_t       st_i,
  output gcer_pkg::relax_res_t         res_o
);

  always_comb begin
    logic [gcer_pkg::COLOR_W-1:0] rc;
    logic [gcer_pkg::COLOR_W-1:0] nc;
    logic                         viol;

    res_o          = '0;
    res_o.running  = st_i.running;
    res_o.violated = st_i.violated;
    res_o.in_prog  = st_i.in_prog;
    res_o.over     = st_i.over;
    rc             = st_i.running;
    nc             = st_i.stale ? snap_rd_i : nbr_rd_i;
    viol           = st_i.violated;

    case (cmd_i)
      gcer_pkg::CMD_WRITE: begin
        res_o.color       = value_i;
        res_o.color_we    = 1'b1;
        res_o.color_wdata = value_i;
      end
      gcer_pkg::CMD_SNAPSHOT: begin
        res_o.color   = nbr_rd_i;
        res_o.snap_we = 1'b1;
      end
      gcer_pkg::CMD_VISIT: begin
        // Start a new vertex from its stored color
        if (!st_i.in_prog) begin
          rc   = vtx_rd_i;
          viol = 1'b0;
        end
        // Lower toward an upward neighbor that is not above
        if (vertex_i < neighbor_i && $signed(rc) >= $signed(nc)) begin
          viol = 1'b1;
          rc   = nc;
        end
        res_o.color   = rc;
        res_o.in_prog = 1'b1;
        // Close the vertex and write back on a violation
        if (last_i) begin
          if (viol) begin
            if (rc != gcer_pkg::COLOR_MIN) begin
              rc = rc - gcer_pkg::COLOR_W'(1);
            end
            res_o.color       = rc;
            res_o.color_we    = 1'b1;
            res_o.color_wdata = rc;
            res_o.over        = 1'b1;
            res_o.changed     = 1'b1;
          end
          viol          = 1'b0;
          res_o.in_prog = 1'b0;
        end
        res_o.running  = rc;
        res_o.violated = viol;
      end
      gcer_pkg::CMD_READ: begin
        res_o.color = vtx_rd_i;
      end
      gcer_pkg::CMD_CLEAR: begin
        res_o.over = 1'b0;
      end
      default: begin
        res_o.color = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/gcer_checker.sv
// Port-level checks for the edge relaxer, bound to the top level.
module gcer_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] color_o,
  input logic        changed_o,
  input logic        over_o
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(color_o))
    else $error("stalled result beat changed");

  // Take no new command in the cycle after one is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command accepted in back-to-back cycles");

  // Raise the over flag with every stored color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && changed_o |-> over_o)
    else $error("color stored without over flag");

  // Never store the top color: a lowered color is decremented or saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && changed_o |-> color_o != 32'h7FFF_FFFF)
    else $error("stored color not decremented");

endmodule

bind graph_coloring_edge_relaxer gcer_checker u_gcer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .color_o     (color_o),
  .changed_o   (changed_o),
  .over_o      (over_o)
);

FILE: tb/graph_coloring_edge_relaxer_test.sv
// Self-checking testbench for the graph coloring edge relaxer.
`timescale 1ns / 100ps

module graph_coloring_edge_relaxer_test;
  import gcer_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int MAX_REPORTS    = 40;

  // Command codes the block decodes as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Directed rows either carry a typed-in result or defer to the predictor
  localparam bit GOLD = 1'b1;
  localparam bit CALC = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [NODE_AW-1:0] vertex;
    logic [NODE_AW-1:0] neighbor;
    logic [EDGE_AW-1:0] eidx;
    logic [COLOR_W-1:0] value;
    logic               last;
  } cmd_beat_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               changed;
    logic               over;
  } result_beat_t;

  typedef struct {
    bit           cfg_row;
    bit           stale_val;
    cmd_beat_t    beat;
    bit           golden;
    result_beat_t gold;
  } vector_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic                      cfg_snap_sel_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [2:0]                cmd_i;
  logic [13:0]               vertex_i;
  logic [13:0]               neighbor_i;
  logic [15:0]               edge_index_i;
  logic signed [31:0]        color_value_i;
  logic                      last_edge_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [31:0]        color_o;
  logic                      changed_o;
  logic                      over_o;

  graph_coloring_edge_relaxer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_snap_sel_i   (cfg_snap_sel_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .vertex_i         (vertex_i),
    .neighbor_i       (neighbor_i),
    .edge_index_i     (edge_index_i),
    .color_value_i    (color_value_i),
    .last_edge_i      (last_edge_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .color_o          (color_o),
    .changed_o        (changed_o),
    .over_o           (over_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Predictor state: mirrored tables, walk registers and stale select
  logic [COLOR_W-1:0] color_mem [MAX_NODES];
  logic [COLOR_W-1:0] snap_mem  [MAX_EDGES];
  bit                 color_known [MAX_NODES];
  bit                 snap_known  [MAX_EDGES];
  logic [NODE_AW-1:0] known_vtx[$];
  logic [EDGE_AW-1:0] known_edge[$];
  logic [COLOR_W-1:0] walk_color;
  bit                 walk_violated;
  bit                 walk_active;
  bit                 over_sticky;
  bit                 stale_sel;

  result_beat_t       relax_results_due[$];
  int                 n_errors;
  int                 useful_sent;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 quiet_cycles;

  task automatic report_mismatch(input string msg);
    n_errors++;
    // keep the log short when the block is badly off
    if (n_errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void store_color(input logic [NODE_AW-1:0] vtx,
                                      input logic [COLOR_W-1:0] val);
    color_mem[vtx] = val;
    if (!color_known[vtx]) begin
      color_known[vtx] = 1'b1;
      known_vtx.push_back(vtx);
    end
  endfunction

  // Step the predictor by one accepted command; field widths match the tables,
  // so no index can fall outside them
  function automatic void relax_predict(input cmd_beat_t b, output result_beat_t r);
    logic [COLOR_W-1:0] nbr_color;
    r = '0;
    case (b.cmd)
      CMD_WRITE: begin
        store_color(b.vertex, b.value);
        r.color = b.value;
      end
      CMD_SNAPSHOT: begin
        r.color = color_mem[b.neighbor];
        snap_mem[b.eidx] = r.color;
        if (!snap_known[b.eidx]) begin
          snap_known[b.eidx] = 1'b1;
          known_edge.push_back(b.eidx);
        end
      end
      CMD_VISIT: begin
        // first edge of a vertex loads its current color
        if (!walk_active) begin
          walk_color    = color_mem[b.vertex];
          walk_violated = 1'b0;
          walk_active   = 1'b1;
        end
        if (b.vertex < b.neighbor) begin
          nbr_color = stale_sel ? snap_mem[b.eidx] : color_mem[b.neighbor];
          if ($signed(walk_color) >= $signed(nbr_color)) begin
            walk_violated = 1'b1;
            walk_color    = nbr_color;
          end
        end
        r.color = walk_color;
        if (b.last) begin
          // write back one below, holding at the most negative color
          if (walk_violated) begin
            if (walk_color != COLOR_MIN) walk_color = walk_color - 1;
            r.color   = walk_color;
            store_color(b.vertex, walk_color);
            over_sticky = 1'b1;
            r.changed   = 1'b1;
          end
          walk_violated = 1'b0;
          walk_active   = 1'b0;
        end
      end
      CMD_READ:  r.color = color_mem[b.vertex];
      CMD_CLEAR: over_sticky = 1'b0;
      default: ;
    endcase
    r.over = over_sticky;
  endfunction

  function automatic cmd_beat_t mk_beat(input logic [CMD_W-1:0] cmd,
                                        input logic [NODE_AW-1:0] vtx,
                                        input logic [NODE_AW-1:0] nbr,
                                        input logic [EDGE_AW-1:0] eidx,
                                        input logic [COLOR_W-1:0] val,
                                        input logic last);
    cmd_beat_t b;
    b.cmd      = cmd;
    b.vertex   = vtx;
    b.neighbor = nbr;
    b.eidx     = eidx;
    b.value    = val;
    b.last     = last;
    return b;
  endfunction

  function automatic vector_row_t vrow(input logic [CMD_W-1:0] cmd, input int vtx,
                                       input int nbr, input int eidx,
                                       input logic [COLOR_W-1:0] val, input bit last,
                                       input bit golden, input logic [COLOR_W-1:0] g_color,
                                       input bit g_changed, input bit g_over);
    vector_row_t row;
    row.cfg_row   = 1'b0;
    row.stale_val = 1'b0;
    row.beat      = mk_beat(cmd, NODE_AW'(vtx), NODE_AW'(nbr), EDGE_AW'(eidx), val, last);
    row.golden    = golden;
    row.gold      = '{g_color, g_changed, g_over};
    return row;
  endfunction

  function automatic vector_row_t cfg_row(input bit stale);
    vector_row_t row;
    row           = vrow(CMD_CLEAR, 0, 0, 0, '0, 1'b0, CALC, '0, 1'b0, 1'b0);
    row.cfg_row   = 1'b1;
    row.stale_val = stale;
    return row;
  endfunction

  function automatic logic [NODE_AW-1:0] pick_vertex();
    return known_vtx[$urandom_range(0, known_vtx.size() - 1)];
  endfunction

  function automatic logic [EDGE_AW-1:0] pick_edge();
    return known_edge[$urandom_range(0, known_edge.size() - 1)];
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(0, 9))
      0:       return COLOR_MIN;
      1:       return ~COLOR_MIN;
      2, 3:    return $urandom;
      default: return COLOR_W'($signed($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  // Present one beat at a falling edge, hold it until accepted, then predict
  task automatic push_beat(input cmd_beat_t b, input bit golden = 1'b0,
                           input result_beat_t gold = '0);
    result_beat_t r;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= b.cmd;
    vertex_i      <= b.vertex;
    neighbor_i    <= b.neighbor;
    edge_index_i  <= b.eidx;
    color_value_i <= b.value;
    last_edge_i   <= b.last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    relax_predict(b, r);
    relax_results_due.push_back(golden ? gold : r);
    if (b.cmd <= CMD_CLEAR) useful_sent++;
  endtask

  // Drain the block, then write the snapshot select bit
  task automatic write_snap_sel(input bit stale);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (relax_results_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_snap_sel_i <= stale;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    stale_sel = stale;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Table writes, snapshots, reads, clears and spare codes
  task automatic side_command();
    int                 roll;
    logic [NODE_AW-1:0] vtx;
    logic [EDGE_AW-1:0] eidx;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      case ($urandom_range(0, 2))
        0:       vtx = pick_vertex();
        1:       vtx = NODE_AW'($urandom_range(0, 63));
        default: vtx = NODE_AW'($urandom);
      endcase
      push_beat(mk_beat(CMD_WRITE, vtx, NODE_AW'($urandom), EDGE_AW'($urandom),
                        rand_color(), 1'($urandom)));
    end else if (roll < 62) begin
      case ($urandom_range(0, 2))
        0:       eidx = pick_edge();
        1:       eidx = EDGE_AW'($urandom_range(0, 255));
        default: eidx = EDGE_AW'($urandom);
      endcase
      push_beat(mk_beat(CMD_SNAPSHOT, NODE_AW'($urandom), pick_vertex(), eidx,
                        $urandom, 1'($urandom)));
    end else if (roll < 82) begin
      push_beat(mk_beat(CMD_READ, pick_vertex(), NODE_AW'($urandom), EDGE_AW'($urandom),
                        $urandom, 1'($urandom)));
    end else if (roll < 92) begin
      push_beat(mk_beat(CMD_CLEAR, NODE_AW'($urandom), NODE_AW'($urandom),
                        EDGE_AW'($urandom), $urandom, 1'($urandom)));
    end else begin
      push_beat(mk_beat(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                        NODE_AW'($urandom), NODE_AW'($urandom), EDGE_AW'($urandom),
                        $urandom, 1'($urandom)));
    end
  endtask

  // Walk one vertex's edge list; an open walk leaves the vertex in progress.
  // Only entries already written are ever read.
  task automatic visit_walk(input int n_edges, input bit closed);
    logic [NODE_AW-1:0] home;
    logic [NODE_AW-1:0] vtx;
    logic [NODE_AW-1:0] nbr;
    logic [EDGE_AW-1:0] eidx;
    home = pick_vertex();
    for (int i = 0; i < n_edges; i++) begin
      vtx = home;
      // a stray vertex field once the walk is under way
      if (i > 0 && $urandom_range(0, 9) == 0) vtx = NODE_AW'($urandom);
      eidx = EDGE_AW'($urandom);
      if ($urandom_range(0, 9) < 3) begin
        nbr = NODE_AW'($urandom_range(0, vtx));
      end else if (stale_sel) begin
        nbr  = NODE_AW'($urandom);
        eidx = pick_edge();
      end else begin
        nbr = pick_vertex();
      end
      push_beat(mk_beat(CMD_VISIT, vtx, nbr, eidx, $urandom,
                        closed && (i == n_edges - 1)));
      if (i < n_edges - 1 && $urandom_range(0, 99) < 15) side_command();
    end
  endtask

  task automatic random_traffic(input int n_items);
    int start;
    int roll;
    start = useful_sent;
    while (useful_sent - start < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 60)      visit_walk($urandom_range(1, 4), 1'b1);
      else if (roll < 68) visit_walk($urandom_range(1, 2), 1'b0);
      else                side_command();
    end
  endtask

  // Receiver stall, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Compare every taken result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    result_beat_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (relax_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result color %h", color_o));
      end else begin
        want = relax_results_due.pop_front();
        if (color_o !== want.color)
          report_mismatch($sformatf("color %h, want %h", color_o, want.color));
        if (changed_o !== want.changed)
          report_mismatch($sformatf("changed %b, want %b", changed_o, want.changed));
        if (over_o !== want.over)
          report_mismatch($sformatf("over %b, want %b", over_o, want.over));
      end
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0) ||
        (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    vector_row_t directed_q[$];
    vector_row_t row;

    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_snap_sel_i   = 1'b0;
    in_valid_i       = 1'b0;
    cmd_i            = '0;
    vertex_i         = '0;
    neighbor_i       = '0;
    edge_index_i     = '0;
    color_value_i    = '0;
    last_edge_i      = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    n_errors         = 0;
    useful_sent      = 0;
    quiet_cycles     = 0;
    walk_color       = '0;
    walk_violated    = 1'b0;
    walk_active      = 1'b0;
    over_sticky      = 1'b0;
    stale_sel        = 1'b0;

    // Directed vectors: extremes, every command, equal and downward edges,
    // saturation, commands between edges, a moving vertex field, stale reads
    directed_q.push_back(vrow(CMD_WRITE, 0, 0, 0, 32'h7FFF_FFFF, 1'b0,
                              GOLD, 32'h7FFF_FFFF, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_WRITE, 16383, 0, 0, 32'h8000_0000, 1'b0,
                              GOLD, 32'h8000_0000, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_WRITE, 100, 0, 0, 32'd5, 1'b0,
                              GOLD, 32'd5, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_WRITE, 200, 0, 0, 32'd5, 1'b0,
                              GOLD, 32'd5, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_READ, 0, 16383, 65535, 32'hFFFF_FFFF, 1'b1,
                              GOLD, 32'h7FFF_FFFF, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_SNAPSHOT, 0, 200, 65535, '0, 1'b0,
                              GOLD, 32'd5, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_SNAPSHOT, 0, 16383, 0, '0, 1'b0,
                              GOLD, 32'h8000_0000, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_VISIT, 100, 200, 1, '0, 1'b1,
                              GOLD, 32'd4, 1'b1, 1'b1));
    directed_q.push_back(vrow(CMD_CLEAR, 0, 0, 0, '0, 1'b0,
                              GOLD, 32'd0, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_VISIT, 100, 50, 2, '0, 1'b0,
                              GOLD, 32'd4, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_VISIT, 100, 100, 3, '0, 1'b0,
                              GOLD, 32'd4, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_VISIT, 100, 16383, 4, '0, 1'b1,
                              GOLD, 32'h8000_0000, 1'b1, 1'b1));
    directed_q.push_back(vrow(CMD_VISIT, 16383, 0, 5, '0, 1'b1,
                              GOLD, 32'h8000_0000, 1'b0, 1'b1));
    directed_q.push_back(vrow(CMD_WRITE, 300, 0, 0, 32'd10, 1'b0,
                              GOLD, 32'd10, 1'b0, 1'b1));
    directed_q.push_back(vrow(CMD_WRITE, 400, 0, 0, 32'd20, 1'b0,
                              GOLD, 32'd20, 1'b0, 1'b1));
    directed_q.push_back(vrow(CMD_VISIT, 300, 400, 6, '0, 1'b1,
                              GOLD, 32'd10, 1'b0, 1'b1));
    directed_q.push_back(vrow(CMD_VISIT, 300, 0, 7, '0, 1'b0,
                              GOLD, 32'd10, 1'b0, 1'b1));
    directed_q.push_back(vrow(CMD_WRITE, 500, 0, 0, 32'hFFFF_FFFD, 1'b0,
                              GOLD, 32'hFFFF_FFFD, 1'b0, 1'b1));
    directed_q.push_back(vrow(CMD_VISIT, 300, 500, 8, '0, 1'b0,
                              GOLD, 32'hFFFF_FFFD, 1'b0, 1'b1));
    directed_q.push_back(vrow(CMD_VISIT, 200, 16383, 9, '0, 1'b1,
                              CALC, '0, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_SPARE_HI, 16383, 16383, 65535, 32'hFFFF_FFFF, 1'b1,
                              GOLD, 32'd0, 1'b0, 1'b1));
    directed_q.push_back(cfg_row(1'b1));
    directed_q.push_back(vrow(CMD_SNAPSHOT, 0, 400, 7, '0, 1'b0,
                              CALC, '0, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_WRITE, 400, 0, 0, 32'hFFFF_FF9C, 1'b0,
                              GOLD, 32'hFFFF_FF9C, 1'b0, 1'b1));
    directed_q.push_back(vrow(CMD_VISIT, 300, 400, 7, '0, 1'b1,
                              CALC, '0, 1'b0, 1'b0));
    directed_q.push_back(vrow(CMD_VISIT, 300, 400, 0, '0, 1'b1,
                              CALC, '0, 1'b0, 1'b0));
    directed_q.push_back(cfg_row(1'b0));

    // Hold reset, release it on a falling edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_q[i]) begin
      row = directed_q[i];
      if (row.cfg_row) write_snap_sel(row.stale_val);
      else             push_beat(row.beat, row.golden, row.gold);
    end

    // Random phases: each idling profile under both stale settings
    for (int phase = 0; phase < 8; phase++) begin
      write_snap_sel(phase[0]);
      case (phase >> 1)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      random_traffic(PHASE_ITEMS);
    end

    // Drop valid, drain, and keep watching for stray beats
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (relax_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/gcer_pkg.sv
rtl/core/gcer_ram.sv
rtl/core/gcer_relax.sv
rtl/core/graph_coloring_edge_relaxer.sv
rtl/core/gcer_checker.sv
tb/graph_coloring_edge_relaxer_test.sv
